// File: design/ss_pkg.sv
// ----------------------------------------------------------------------------
// Substring search package
// Shared constants, register codes, configuration type and the needle byte
// lookup used by the substring search block.
// ----------------------------------------------------------------------------
package ss_pkg;

  // Largest needle the window can hold.
  localparam int unsigned MaxNeedle = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 32;
  localparam int unsigned NlenW     = 5;
  localparam int unsigned NidxW     = 4;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned WordW     = 64;
  localparam int unsigned AddrW     = 6;

  localparam logic [PosW-1:0]  CountMax  = '1;
  localparam logic [NlenW-1:0] NlenLimit = NlenW'(MaxNeedle);

  // Register index, taken from address bits [5:3].
  typedef enum logic [2:0] {
    RegMode   = 3'd0,
    RegNlen   = 3'd1,
    RegNlow   = 3'd2,
    RegNhigh  = 3'd3,
    RegLimit  = 3'd4
  } ss_reg_e;

  // Search modes; the code 3 behaves as raw memory mode.
  typedef enum logic [ModeW-1:0] {
    ModeString  = 2'd0,
    ModeBounded = 2'd1,
    ModeMemory  = 2'd2
  } ss_mode_e;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [NlenW-1:0] nlen;
    logic [WordW-1:0] needle_lo;
    logic [WordW-1:0] needle_hi;
    logic [PosW-1:0]  limit;
  } ss_cfg_t;

  // Picks needle byte j out of the two needle words.
  function automatic logic [ByteW-1:0] needle_byte(input logic [WordW-1:0] lo,
                                                   input logic [WordW-1:0] hi,
                                                   input logic [NidxW-1:0] j);
    logic [5:0] sh;
    sh = {j[2:0], 3'b000};
    return j[3] ? hi[sh +: ByteW] : lo[sh +: ByteW];
  endfunction

endpackage

// File: design/ss_cell.sv
// ----------------------------------------------------------------------------
// Substring search window cell
// Holds one byte of the haystack window, passes it to the next cell on each
// shift and compares the byte it takes in with its needle byte.
// ----------------------------------------------------------------------------
module ss_cell (
  input  logic                    clk_i,
  input  logic                    shift_i,
  input  logic [ss_pkg::ByteW-1:0] byte_i,
  input  logic [ss_pkg::ByteW-1:0] needle_byte_i,
  input  logic                    active_i,
  output logic [ss_pkg::ByteW-1:0] byte_o,
  output logic                    hit_o
);

  logic [ss_pkg::ByteW-1:0] byte_q;

  // Window byte, moved one place along the chain on each shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // Compare the byte entering this cell; unused cells always agree.
  assign hit_o  = !active_i || (byte_i == needle_byte_i);
  assign byte_o = byte_q;

endmodule

// File: design/ss_regs.sv
// ----------------------------------------------------------------------------
// Substring search register file
// APB-style configuration registers: mode, needle length, needle words and
// the byte limit of bounded mode.
// ----------------------------------------------------------------------------
module ss_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ss_pkg::AddrW-1:0] paddr,
  input  logic [ss_pkg::WordW-1:0] pwdata,
  output logic [ss_pkg::WordW-1:0] prdata,
  output logic                     pready,
  output ss_pkg::ss_cfg_t          cfg_o
);

  ss_pkg::ss_cfg_t cfg_q;
  ss_pkg::ss_reg_e idx;
  logic            wr_en;

  assign idx    = ss_pkg::ss_reg_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= ss_pkg::ModeString;
      cfg_q.nlen      <= '0;
      cfg_q.needle_lo <= '0;
      cfg_q.needle_hi <= '0;
      cfg_q.limit     <= ss_pkg::CountMax;
    end else if (wr_en) begin
      case (idx)
        ss_pkg::RegMode:  cfg_q.mode      <= pwdata[ss_pkg::ModeW-1:0];
        ss_pkg::RegNlen:  cfg_q.nlen      <= pwdata[ss_pkg::NlenW-1:0];
        ss_pkg::RegNlow:  cfg_q.needle_lo <= pwdata;
        ss_pkg::RegNhigh: cfg_q.needle_hi <= pwdata;
        ss_pkg::RegLimit: cfg_q.limit     <= pwdata[ss_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      ss_pkg::RegMode:  prdata = ss_pkg::WordW'(cfg_q.mode);
      ss_pkg::RegNlen:  prdata = ss_pkg::WordW'(cfg_q.nlen);
      ss_pkg::RegNlow:  prdata = cfg_q.needle_lo;
      ss_pkg::RegNhigh: prdata = cfg_q.needle_hi;
      ss_pkg::RegLimit: prdata = ss_pkg::WordW'(cfg_q.limit);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/substring_search.sv
// The deciding byte's result word is registered in the output stage (or the
// skid entry on a stall). Throughput: one haystack byte per cycle while the
// skid entry is empty; all sixteen window cells compare in the cycle the
// byte enters, and a two-entry output stage absorbs stalls.
// Reset (rst_ni low, asynchronous) clears the search state, the output stage
// and the registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Substring search top level
// Streams haystack bytes through a chain of window cells and reports the
// first occurrence of the configured needle, one result word per search.
// ----------------------------------------------------------------------------
module substring_search (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Haystack words
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] data_byte
  input  logic                     s_axis_tlast,   // last
  // Result words
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [31:0]              m_axis_tdata,   // [31:0] position
  output logic                     m_axis_tuser,   // [0] found
  // Configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ss_pkg::AddrW-1:0] paddr,
  input  logic [ss_pkg::WordW-1:0] pwdata,
  output logic [ss_pkg::WordW-1:0] prdata,
  output logic                     pready
);

  localparam int unsigned N  = ss_pkg::MaxNeedle;
  localparam int unsigned BW = ss_pkg::ByteW;
  localparam int unsigned PW = ss_pkg::PosW;

  ss_pkg::ss_cfg_t cfg;

  logic                    accept;
  logic                    shift;
  logic [ss_pkg::NlenW-1:0] nlen;
  logic [PW-1:0]           nlen_w;
  logic [PW-1:0]           seen_q, seen_d, cnt_next;
  logic                    decided_q, decided_d;
  logic [BW-1:0]           chain [N+1];
  logic [N-1:0]            hits;
  logic                    string_mode, is_empty, is_nul, is_match, is_lim;
  logic                    emit, res_found;
  logic [PW-1:0]           res_pos;

  logic                    out_valid_q, skid_valid_q;
  logic                    out_found_q, skid_found_q;
  logic [PW-1:0]           out_pos_q, skid_pos_q;
  logic                    out_take;

  // Configuration registers.
  ss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake and needle length clamp.
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign shift         = accept && !decided_q;
  assign nlen          = (cfg.nlen > ss_pkg::NlenLimit) ? ss_pkg::NlenLimit : cfg.nlen;
  assign nlen_w        = PW'(nlen);

  // Window chain: cell k takes in the byte k places back and checks it against
  // needle byte nlen-1-k.
  assign chain[0] = s_axis_tdata;
  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam logic [ss_pkg::NlenW-1:0] Pos = ss_pkg::NlenW'(k);
    logic                    active;
    logic [ss_pkg::NidxW-1:0] nidx;
    logic [ss_pkg::NlenW-1:0] diff;

    assign active = Pos < nlen;
    assign diff   = nlen - 5'd1 - Pos;
    assign nidx   = diff[ss_pkg::NidxW-1:0];

    ss_cell u_cell (
      .clk_i         (clk_i),
      .shift_i       (shift),
      .byte_i        (chain[k]),
      .needle_byte_i (ss_pkg::needle_byte(cfg.needle_lo, cfg.needle_hi, nidx)),
      .active_i      (active),
      .byte_o        (chain[k+1]),
      .hit_o         (hits[k])
    );
  end

  // Decision on the incoming byte, in priority order.
  assign cnt_next    = (seen_q == ss_pkg::CountMax) ? seen_q : seen_q + 32'd1;
  assign string_mode = (cfg.mode == ss_pkg::ModeString) ||
                       (cfg.mode == ss_pkg::ModeBounded);
  assign is_empty    = (nlen == '0);
  assign is_nul      = string_mode && (s_axis_tdata == '0);
  assign is_match    = (cnt_next >= nlen_w) && (&hits);
  assign is_lim      = (cfg.mode == ss_pkg::ModeBounded) && (cnt_next >= cfg.limit);
  assign emit        = shift && (is_empty || is_nul || is_match || is_lim || s_axis_tlast);
  assign res_found   = is_empty || (!is_nul && is_match);
  assign res_pos     = (!is_empty && res_found) ? (cnt_next - nlen_w) : '0;

  // Search state; the last byte always starts a fresh search.
  always_comb begin
    seen_d    = seen_q;
    decided_d = decided_q;
    if (accept) begin
      if (s_axis_tlast) begin
        seen_d    = '0;
        decided_d = 1'b0;
      end else if (!decided_q) begin
        seen_d    = cnt_next;
        decided_d = emit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      decided_q <= 1'b0;
    end else begin
      seen_q    <= seen_d;
      decided_q <= decided_d;
    end
  end

  // Output register with a skid entry behind it.
  assign out_take = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (emit) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_found_q <= skid_found_q;
        out_pos_q   <= skid_pos_q;
      end
    end else if (emit) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_found_q <= res_found;
        skid_pos_q   <= res_pos;
      end else begin
        out_found_q <= res_found;
        out_pos_q   <= res_pos;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pos_q;
  assign m_axis_tuser  = out_found_q;

  // The skid entry is only ever filled behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a word while the output register is empty");

  // A decision that is not on the last byte closes the search.
  a_decided_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !s_axis_tlast) |=> decided_q)
    else $error("search not marked decided after its result");

  // A miss always reports position zero.
  a_miss_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss reported with a nonzero position");

  // The last byte restarts the byte count.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (seen_q == '0 && !decided_q))
    else $error("search state not cleared after the last byte");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Substring search testbench
// Drives haystack words into the search block and configures it over the
// register port. A software copy of the search predicts each result word,
// and the monitor compares the results field by field. A short directed run
// comes first, then randomized phases with random needles, modes and limits.
// ----------------------------------------------------------------------------
module tb_top;

  // Mode code 3 has no name in the package and acts as raw memory mode.
  localparam logic [ss_pkg::ModeW-1:0] ModeSpare = 2'd3;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;   // wait for all pending results before sending
  } hay_word_t;

  typedef struct {
    logic        found;
    logic [31:0] position;
  } match_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata  = '0;  // [7:0] data_byte
  logic                     s_axis_tlast  = 1'b0;  // last
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [31:0]              m_axis_tdata;        // [31:0] position
  logic                     m_axis_tuser;        // [0] found
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [ss_pkg::AddrW-1:0] paddr   = '0;
  logic [ss_pkg::WordW-1:0] pwdata  = '0;
  logic [ss_pkg::WordW-1:0] prdata;
  logic                     pready;

  // Pending haystack words and expected result words.
  hay_word_t hay_q[$];
  match_t    match_q[$];
  hay_word_t cur_word;

  // Shadow copy of the configuration registers.
  logic [ss_pkg::ModeW-1:0] cfg_mode  = ss_pkg::ModeString;
  logic [4:0]               cfg_nlen  = '0;
  logic [63:0]              cfg_nlo   = '0;
  logic [63:0]              cfg_nhi   = '0;
  logic [31:0]              cfg_limit = '1;

  // Shadow copy of the search state.
  logic [7:0]  hay_win[16];
  logic [31:0] hay_count = '0;
  bit          settled   = 1'b0;

  int unsigned queued_bytes = 0;
  int unsigned sent_bytes   = 0;
  int unsigned scanned      = 0;
  int unsigned searches     = 0;
  int unsigned hits         = 0;
  int unsigned phases       = 0;
  int unsigned errors       = 0;
  int unsigned tx_gap       = 0;
  int unsigned rx_stall     = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;

  substring_search u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // Advances the shadow search by one haystack byte and queues any result.
  function automatic void search_step(input logic [7:0] b, input logic last);
    logic [127:0] needle;
    int unsigned  n;
    int           k;
    bit           emit;
    bit           hit;
    bit           same;
    bit           str_mode;
    logic [31:0]  pos;
    needle   = {cfg_nhi, cfg_nlo};
    n        = (cfg_nlen > ss_pkg::MaxNeedle) ? ss_pkg::MaxNeedle : cfg_nlen;
    str_mode = (cfg_mode == ss_pkg::ModeString) || (cfg_mode == ss_pkg::ModeBounded);
    if (!settled) begin
      scanned++;
      for (k = 15; k > 0; k--) hay_win[k] = hay_win[k-1];
      hay_win[0] = b;
      if (hay_count != '1) hay_count++;
      same = 1'b1;
      for (k = 0; k < int'(n); k++) begin
        if (hay_win[int'(n) - 1 - k] != needle[8*k +: 8]) same = 1'b0;
      end
      emit = 1'b0;
      hit  = 1'b0;
      pos  = '0;
      if (n == 0) begin
        emit = 1'b1;
        hit  = 1'b1;
      end else if (str_mode && b == 8'h00) begin
        emit = 1'b1;
      end else if (hay_count >= n && same) begin
        emit = 1'b1;
        hit  = 1'b1;
        pos  = hay_count - n;
      end else if (cfg_mode == ss_pkg::ModeBounded && hay_count >= cfg_limit) begin
        emit = 1'b1;
      end else if (last) begin
        emit = 1'b1;
      end
      if (emit) begin
        settled = 1'b1;
        match_q.push_back('{found: hit, position: pos});
      end
    end
    if (last) begin
      for (k = 0; k < 16; k++) hay_win[k] = '0;
      hay_count = '0;
      settled   = 1'b0;
    end
  endfunction

  // Haystack driver: one word per handshake, random gap before each word.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        search_step(cur_word.data, cur_word.last);
        sent_bytes++;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 17);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (hay_q.size() > 0 && !(hay_q[0].hold && match_q.size() > 0)) begin
          cur_word = hay_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_word.data;
          s_axis_tlast  <= cur_word.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each word and stalls at random after it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        searches++;
        if (match_q.size() == 0) begin
          report($sformatf("result word with no search pending (found %0b pos %0d)",
                           m_axis_tuser, m_axis_tdata));
        end else begin
          match_t want;
          want = match_q.pop_front();
          if (want.found) hits++;
          if (m_axis_tuser !== want.found)
            report($sformatf("found is %b, expected %b", m_axis_tuser, want.found));
          if (m_axis_tdata !== want.position)
            report($sformatf("position is %0d, expected %0d", m_axis_tdata, want.position));
        end
        rx_stall = rx_calm ? 0 : $urandom_range(0, 17);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input ss_pkg::ss_reg_e idx, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ss_pkg::RegMode:  cfg_mode  = value[ss_pkg::ModeW-1:0];
      ss_pkg::RegNlen:  cfg_nlen  = value[4:0];
      ss_pkg::RegNlow:  cfg_nlo   = value;
      ss_pkg::RegNhigh: cfg_nhi   = value;
      ss_pkg::RegLimit: cfg_limit = value[31:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [ss_pkg::ModeW-1:0] mode, input logic [4:0] nlen,
                            input logic [127:0] needle, input logic [31:0] limit);
    write_reg(ss_pkg::RegMode, 64'(mode));
    write_reg(ss_pkg::RegNlen, 64'(nlen));
    write_reg(ss_pkg::RegNlow, needle[63:0]);
    write_reg(ss_pkg::RegNhigh, needle[127:64]);
    write_reg(ss_pkg::RegLimit, 64'(limit));
    phases++;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last, input bit hold);
    hay_q.push_back('{data: b, last: last, hold: hold});
    queued_bytes++;
  endtask

  // Waits until every word is sent and every result checked, then settles.
  task automatic drain();
    while (sent_bytes != queued_bytes || match_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One random haystack; the needle is planted in most of them.
  task automatic queue_search(input int unsigned len, input bit hold);
    logic [127:0] needle;
    logic [7:0]   alt0;
    logic [7:0]   alt1;
    logic [7:0]   b;
    int unsigned  n;
    int unsigned  at;
    int unsigned  i;
    int unsigned  r;
    bit           plant;
    needle = {cfg_nhi, cfg_nlo};
    n      = (cfg_nlen > ss_pkg::MaxNeedle) ? ss_pkg::MaxNeedle : cfg_nlen;
    alt0   = $urandom_range(1, 255);
    alt1   = $urandom_range(1, 255);
    plant  = (n > 0) && (len >= n) && ($urandom_range(0, 3) != 0);
    at     = plant ? $urandom_range(0, len - n) : 0;
    for (i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (plant && i >= at && i < at + n) b = needle[8*(i-at) +: 8];
      else if (r < 5 && n > 0) b = needle[8*$urandom_range(0, n - 1) +: 8];
      else if (r < 8) b = r[0] ? alt0 : alt1;
      else b = $urandom_range(0, 255);
      add_byte(b, i == len - 1, hold && i == 0);
    end
  endtask

  initial begin
    logic [127:0]             needle;
    logic [ss_pkg::ModeW-1:0] mode;
    logic [4:0]               nlen;
    logic [31:0]              limit;
    int unsigned              r;
    int unsigned              j;
    int unsigned              len;
    int unsigned              count;
    bit                       first;

    for (j = 0; j < 16; j++) hay_win[j] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Registers at reset: empty needle matches at once, even on a NUL.
    add_byte(8'h00, 1'b1, 1'b0);
    drain();

    // String mode: a NUL ends the search before the needle shows up.
    set_config(ss_pkg::ModeString, 5'd2, 128'h6261, '1);
    add_byte(8'h61, 1'b0, 1'b1);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h62, 1'b1, 1'b0);
    drain();

    // Match after a partial match; trailing words are ignored.
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h62, 1'b0, 1'b0);
    add_byte(8'h63, 1'b0, 1'b0);
    add_byte(8'h63, 1'b1, 1'b0);
    drain();

    // Bounded mode: the match would end past the limit.
    set_config(ss_pkg::ModeBounded, 5'd2, 128'h6261, 32'd2);
    add_byte(8'h7f, 1'b0, 1'b0);
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h62, 1'b1, 1'b0);
    drain();

    // Bounded mode with a zero limit and an empty needle still matches.
    set_config(ss_pkg::ModeBounded, 5'd0, 128'h0, 32'd0);
    add_byte(8'h80, 1'b1, 1'b0);
    drain();

    // Memory mode: NUL is ordinary data and can be part of the needle.
    set_config(ss_pkg::ModeMemory, 5'd2, 128'hff00, '1);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hff, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'h12, 1'b0, 1'b0);
    add_byte(8'h34, 1'b1, 1'b0);
    drain();

    // String mode with a zero needle byte: the NUL ends the search first.
    set_config(ss_pkg::ModeString, 5'd2, 128'hff00, '1);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hff, 1'b1, 1'b0);
    drain();

    // Mode code 3 behaves as memory mode.
    set_config(ModeSpare, 5'd1, 128'h0, 32'd0);
    add_byte(8'h00, 1'b1, 1'b0);
    drain();

    // Random phases until enough bytes have been queued.
    first = 1'b1;
    while (queued_bytes < 600) begin
      r = $urandom_range(0, 9);
      mode = (r < 4) ? ss_pkg::ModeString :
             (r < 7) ? ss_pkg::ModeBounded :
             (r < 9) ? ss_pkg::ModeMemory : ModeSpare;
      r = $urandom_range(0, 15);
      if (r == 0) nlen = 5'd0;
      else if (r == 1) nlen = $urandom_range(17, 31);
      else if (r < 4) nlen = 5'd16;
      else if (r < 10) nlen = $urandom_range(1, 4);
      else nlen = $urandom_range(5, 15);
      needle = {$urandom, $urandom, $urandom, $urandom};
      if ((mode == ss_pkg::ModeString || mode == ss_pkg::ModeBounded) &&
          $urandom_range(0, 7) != 0) begin
        for (j = 0; j < 16; j++)
          if (needle[8*j +: 8] == 8'h00) needle[8*j +: 8] = $urandom_range(1, 255);
      end
      r = $urandom_range(0, 9);
      if (mode != ss_pkg::ModeBounded) limit = $urandom;
      else if (r == 0) limit = '0;
      else if (r == 1) limit = '1;
      else limit = $urandom_range(1, 40);
      set_config(mode, nlen, needle, limit);

      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      count = $urandom_range(2, 6);
      for (j = 0; j < count; j++) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
        queue_search(len, first || $urandom_range(0, 5) == 0);
        first = 1'b0;
      end
      drain();
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d searched bytes over %0d configurations.", scanned, phases);
    $display("Checked %0d result words, %0d of them matches.", searches, hits);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
